### rtl/segint_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package segint_pkg;

	// threshold register: width and value after reset (about 0.02 with 16 fraction bits)
	localparam int THR_WIDTH = 24;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 24'd1311;

	typedef enum logic [1:0] {
		ST_PARALLEL = 2'd0,
		ST_INSIDE   = 2'd1,
		ST_OUTSIDE  = 2'd2
	} status_t;

endpackage
`default_nettype wire

### rtl/segint_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module segint_prep import segint_pkg::*; #(
	parameter int CW = 24,
	parameter int MW = 2 * CW + 2
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	input  wire logic signed [CW-1:0] p1x,
	input  wire logic signed [CW-1:0] p1y,
	input  wire logic signed [CW-1:0] p2x,
	input  wire logic signed [CW-1:0] p2y,
	input  wire logic signed [CW-1:0] q1x,
	input  wire logic signed [CW-1:0] q1y,
	input  wire logic signed [CW-1:0] q2x,
	input  wire logic signed [CW-1:0] q2y,
	input  wire logic [THR_WIDTH-1:0] thr,
	output logic                      o_valid,
	output logic [MW-1:0]             o_dmag,
	output logic [MW-1:0]             o_nmag,
	output logic                      o_pneg,
	output status_t                   o_status,
	output logic signed [CW-1:0]      o_px,
	output logic signed [CW-1:0]      o_py,
	output logic [CW:0]               o_axm,
	output logic [CW:0]               o_aym,
	output logic                      o_axneg,
	output logic                      o_ayneg
);
	localparam int DFW  = CW + 1;
	localparam int PRW  = 2 * CW + 2;
	localparam int DW   = 2 * CW + 3;
	localparam int CMPW = MW + THR_WIDTH;

	logic val_s1, val_s2, val_s3, val_s4, val_s5;

	// stage 1: direction and offset vectors
	logic signed [CW-1:0]  px_s1, py_s1;
	logic signed [DFW-1:0] ax_s1, ay_s1, cx_s1, cy_s1, bx_s1, by_s1;
	// stage 2: cross products
	logic signed [CW-1:0]  px_s2, py_s2;
	logic signed [DFW-1:0] ax_s2, ay_s2;
	logic signed [PRW-1:0] acy_s2, cay_s2, cybx_s2, cxby_s2, aybx_s2, axby_s2;
	// stage 3: determinant and numerators
	logic signed [CW-1:0]  px_s3, py_s3;
	logic signed [DFW-1:0] ax_s3, ay_s3;
	logic signed [DW-1:0]  det_s3, n1_s3, n2_s3;
	// stage 4: magnitudes and signs
	logic signed [CW-1:0]  px_s4, py_s4;
	logic [DFW-1:0]        axm_s4, aym_s4;
	logic                  axneg_s4, ayneg_s4;
	logic [MW-1:0]         dmag_s4, n1mag_s4, n2mag_s4;
	logic                  dneg_s4, n1neg_s4, n2neg_s4, par_s4;

	logic [DW-1:0]  d_abs, n1_abs, n2_abs, ax_abs, ay_abs;
	logic [CMPW-1:0] d_cmp, thr_cmp;
	logic            in1, in2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
		end else begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= p1x;
		py_s1 <= p1y;
		ax_s1 <= {p2x[CW-1], p2x} - {p1x[CW-1], p1x};
		ay_s1 <= {p2y[CW-1], p2y} - {p1y[CW-1], p1y};
		cx_s1 <= {q2x[CW-1], q2x} - {q1x[CW-1], q1x};
		cy_s1 <= {q2y[CW-1], q2y} - {q1y[CW-1], q1y};
		bx_s1 <= {q1x[CW-1], q1x} - {p1x[CW-1], p1x};
		by_s1 <= {q1y[CW-1], q1y} - {p1y[CW-1], p1y};
	end

	always_ff @(posedge clk) begin
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		acy_s2  <= ax_s1 * cy_s1;
		cay_s2  <= cx_s1 * ay_s1;
		cybx_s2 <= cy_s1 * bx_s1;
		cxby_s2 <= cx_s1 * by_s1;
		aybx_s2 <= ay_s1 * bx_s1;
		axby_s2 <= ax_s1 * by_s1;
	end

	always_ff @(posedge clk) begin
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
		det_s3 <= {acy_s2[PRW-1], acy_s2} - {cay_s2[PRW-1], cay_s2};
		n1_s3  <= {cybx_s2[PRW-1], cybx_s2} - {cxby_s2[PRW-1], cxby_s2};
		n2_s3  <= {aybx_s2[PRW-1], aybx_s2} - {axby_s2[PRW-1], axby_s2};
	end

	always_comb begin
		d_abs   = det_s3[DW-1] ? -det_s3 : det_s3;
		n1_abs  = n1_s3[DW-1] ? -n1_s3 : n1_s3;
		n2_abs  = n2_s3[DW-1] ? -n2_s3 : n2_s3;
		ax_abs  = DW'(ax_s3[DFW-1] ? -ax_s3 : ax_s3);
		ay_abs  = DW'(ay_s3[DFW-1] ? -ay_s3 : ay_s3);
		d_cmp   = CMPW'(d_abs[MW-1:0]);
		thr_cmp = CMPW'(thr);
	end

	always_ff @(posedge clk) begin
		px_s4    <= px_s3;
		py_s4    <= py_s3;
		axm_s4   <= ax_abs[DFW-1:0];
		aym_s4   <= ay_abs[DFW-1:0];
		axneg_s4 <= ax_s3[DFW-1];
		ayneg_s4 <= ay_s3[DFW-1];
		dmag_s4  <= d_abs[MW-1:0];
		n1mag_s4 <= n1_abs[MW-1:0];
		n2mag_s4 <= n2_abs[MW-1:0];
		dneg_s4  <= det_s3[DW-1];
		n1neg_s4 <= n1_s3[DW-1];
		n2neg_s4 <= n2_s3[DW-1];
		par_s4   <= d_cmp <= thr_cmp;
	end

	// ratio lies in [0,1]: zero numerator, or same sign and not larger than the determinant
	always_comb begin
		in1 = (n1mag_s4 == '0) || ((n1neg_s4 == dneg_s4) && (n1mag_s4 <= dmag_s4));
		in2 = (n2mag_s4 == '0) || ((n2neg_s4 == dneg_s4) && (n2mag_s4 <= dmag_s4));
	end

	always_ff @(posedge clk) begin
		o_dmag  <= dmag_s4;
		o_nmag  <= n1mag_s4;
		o_pneg  <= n1neg_s4 ^ dneg_s4;
		o_px    <= px_s4;
		o_py    <= py_s4;
		o_axm   <= axm_s4;
		o_aym   <= aym_s4;
		o_axneg <= axneg_s4;
		o_ayneg <= ayneg_s4;
		if (par_s4)
			o_status <= ST_PARALLEL;
		else if (in1 && in2)
			o_status <= ST_INSIDE;
		else
			o_status <= ST_OUTSIDE;
	end

	assign o_valid = val_s5;

endmodule
`default_nettype wire

### rtl/segint_div.sv
`timescale 1ns / 1ps
`default_nettype none
module segint_div #(
	parameter int MW  = 50,
	parameter int PF  = 16,
	parameter int QW  = 42,
	parameter int SDW = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire  [MW-1:0]     dmag,
	input  wire  [MW-1:0]     nmag,
	input  wire  [SDW-1:0]    side_in,
	output logic              o_valid,
	output logic [QW-1:0]     o_pmag,
	output logic [SDW-1:0]    o_side
);
	localparam int NW = MW + PF;
	localparam int XW = MW + QW;
	localparam logic [QW-1:0] LIM = QW'(1) << (QW - 1);

	// one quotient bit per stage, most significant first
	logic           val_s [QW+1];
	logic [NW-1:0]  rem_s [QW+1];
	logic [MW-1:0]  den_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic           ovf_s [QW+1];
	logic [SDW-1:0] side_s [QW+1];

	logic           val_q;
	logic [QW-1:0]  pmag_q;
	logic [SDW-1:0] side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			val_s[0] <= 1'b0;
		else
			val_s[0] <= in_valid;
	end

	// entry: quotient beyond the bit range saturates
	always_ff @(posedge clk) begin
		rem_s[0]  <= {nmag, {PF{1'b0}}};
		den_s[0]  <= dmag;
		quo_s[0]  <= '0;
		ovf_s[0]  <= XW'({nmag, {PF{1'b0}}}) >= {dmag, {QW{1'b0}}};
		side_s[0] <= side_in;
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [XW:0]   diff;
		logic          ge;
		logic [QW-1:0] quo_next;

		always_comb begin
			diff     = {1'b0, XW'(rem_s[j])} - {1'b0, XW'(den_s[j]) << K};
			ge       = !diff[XW];
			quo_next = quo_s[j];
			quo_next[K] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				val_s[j+1] <= 1'b0;
			else
				val_s[j+1] <= val_s[j];
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= ge ? diff[NW-1:0] : rem_s[j];
			den_s[j+1]  <= den_s[j];
			quo_s[j+1]  <= quo_next;
			ovf_s[j+1]  <= ovf_s[j];
			side_s[j+1] <= side_s[j];
		end
	end

	// clamp the parameter magnitude; larger values saturate every point anyway
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			val_q <= 1'b0;
		else
			val_q <= val_s[QW];
	end

	always_ff @(posedge clk) begin
		pmag_q <= (ovf_s[QW] || (quo_s[QW] > LIM)) ? LIM : quo_s[QW];
		side_q <= side_s[QW];
	end

	assign o_valid = val_q;
	assign o_pmag  = pmag_q;
	assign o_side  = side_q;

endmodule
`default_nettype wire

### rtl/segint_place.sv
`timescale 1ns / 1ps
`default_nettype none
module segint_place import segint_pkg::*; #(
	parameter int CW = 24,
	parameter int PF = 16,
	parameter int QW = 42
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire  [QW-1:0]             pmag,
	input  wire  status_t             status_in,
	input  wire  logic signed [CW-1:0] px,
	input  wire  logic signed [CW-1:0] py,
	input  wire  [CW:0]               axm,
	input  wire  [CW:0]               aym,
	input  wire                       xneg,
	input  wire                       yneg,
	output logic                      o_valid,
	output status_t                   o_status,
	output logic signed [CW-1:0]      o_x,
	output logic signed [CW-1:0]      o_y
);
	localparam int L  = (QW + 1) / 2;
	localparam int H  = QW - L;
	localparam int PW = QW + CW + 1;
	localparam int SW = PW + 2;
	localparam longint MAXL = (longint'(1) << (CW - 1)) - 1;
	localparam logic signed [SW-1:0] MAXV = SW'(MAXL);
	localparam logic signed [SW-1:0] MINV = SW'(-MAXL - 1);

	logic val_s1, val_s2, val_s3, val_s4;
	status_t st_s1, st_s2, st_s3, st_s4;
	logic signed [CW-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic xneg_s1, yneg_s1, xneg_s2, yneg_s2;
	logic [L+CW:0] lox_s1, loy_s1;
	logic [H+CW:0] hix_s1, hiy_s1;
	logic [PW-1:0] mx_s2, my_s2;
	logic signed [PW:0] vx_s3, vy_s3;
	logic signed [SW-1:0] sx, sy;
	logic signed [CW-1:0] x_s4, y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
		end else begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
		end
	end

	// split the parameter into two halves to keep each multiplier narrow
	always_ff @(posedge clk) begin
		st_s1   <= status_in;
		px_s1   <= px;
		py_s1   <= py;
		xneg_s1 <= xneg;
		yneg_s1 <= yneg;
		lox_s1  <= pmag[L-1:0] * axm;
		loy_s1  <= pmag[L-1:0] * aym;
		hix_s1  <= pmag[QW-1:L] * axm;
		hiy_s1  <= pmag[QW-1:L] * aym;
	end

	always_ff @(posedge clk) begin
		st_s2   <= st_s1;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		xneg_s2 <= xneg_s1;
		yneg_s2 <= yneg_s1;
		mx_s2   <= PW'(lox_s1) + (PW'(hix_s1) << L);
		my_s2   <= PW'(loy_s1) + (PW'(hiy_s1) << L);
	end

	always_ff @(posedge clk) begin
		st_s3 <= st_s2;
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		vx_s3 <= xneg_s2 ? -$signed({1'b0, mx_s2}) : $signed({1'b0, mx_s2});
		vy_s3 <= yneg_s2 ? -$signed({1'b0, my_s2}) : $signed({1'b0, my_s2});
	end

	// floor shift, add the start point, saturate
	always_comb begin
		sx = SW'(px_s3) + SW'(vx_s3 >>> PF);
		sy = SW'(py_s3) + SW'(vy_s3 >>> PF);
	end

	always_ff @(posedge clk) begin
		st_s4 <= st_s3;
		if (st_s3 == ST_PARALLEL) begin
			x_s4 <= '0;
			y_s4 <= '0;
		end else begin
			x_s4 <= (sx > MAXV) ? CW'(MAXV) : ((sx < MINV) ? CW'(MINV) : sx[CW-1:0]);
			y_s4 <= (sy > MAXV) ? CW'(MAXV) : ((sy < MINV) ? CW'(MINV) : sy[CW-1:0]);
		end
	end

	assign o_valid  = val_s4;
	assign o_status = st_s4;
	assign o_x      = x_s4;
	assign o_y      = y_s4;

endmodule
`default_nettype wire

### rtl/segment_intersection_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Segment intersection test for two segments in signed fixed point.
//
// Input: pulse start with the eight endpoint coordinates; a word is taken at
// every clock edge where start is high and busy is low. busy never rises, so
// one word can enter every cycle.
// Output: done strobes for one cycle with status, intersect_x and intersect_y.
// Results leave in input order; the receiver must take them in that cycle.
// Pipeline: the restoring divider that retires one quotient bit per stage, plus
// five front stages (vectors, products, determinant, magnitudes, range flags)
// and four back stages (split multiply, sum, sign, shift-add-saturate).
// Throughput: one word per cycle.
// Configuration: cfg_data written with cfg_valid (cfg_ready stays high) sets
// the parallel threshold; write only while the pipeline is empty.
// Reset: clears all valid bits, so no strobe comes out until new words enter;
// the threshold returns to its default of about 0.02.
module segment_intersection_test import segint_pkg::*; #(
	parameter int COORD_WIDTH     = 24,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  logic signed [COORD_WIDTH-1:0] seg1_start_x,
	input  wire  logic signed [COORD_WIDTH-1:0] seg1_start_y,
	input  wire  logic signed [COORD_WIDTH-1:0] seg1_end_x,
	input  wire  logic signed [COORD_WIDTH-1:0] seg1_end_y,
	input  wire  logic signed [COORD_WIDTH-1:0] seg2_start_x,
	input  wire  logic signed [COORD_WIDTH-1:0] seg2_start_y,
	input  wire  logic signed [COORD_WIDTH-1:0] seg2_end_x,
	input  wire  logic signed [COORD_WIDTH-1:0] seg2_end_y,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [THR_WIDTH-1:0]              cfg_data,
	output logic                              done,
	output logic [1:0]                        status,
	output logic signed [COORD_WIDTH-1:0]     intersect_x,
	output logic signed [COORD_WIDTH-1:0]     intersect_y
);
	localparam int CW  = COORD_WIDTH;
	localparam int PF  = PARAM_FRAC_BITS;
	// determinant magnitude bits
	localparam int MW  = 2 * CW + 2;
	// quotient bits; the top one only marks the clamp value
	localparam int QW  = PF + CW + 2;
	// sideband: status, parameter sign, start point, direction magnitudes and signs
	localparam int SDW = 2 + 1 + 2 * CW + 2 * (CW + 1) + 2;

	logic [THR_WIDTH-1:0] thr_q;

	logic                 pre_valid;
	logic [MW-1:0]        pre_dmag, pre_nmag;
	logic                 pre_pneg;
	status_t              pre_status;
	logic signed [CW-1:0] pre_px, pre_py;
	logic [CW:0]          pre_axm, pre_aym;
	logic                 pre_axneg, pre_ayneg;

	logic [SDW-1:0]       side_in, side_out;
	logic                 div_valid;
	logic [QW-1:0]        div_pmag;

	logic [1:0]           sd_status;
	logic                 sd_pneg;
	logic signed [CW-1:0] sd_px, sd_py;
	logic [CW:0]          sd_axm, sd_aym;
	logic                 sd_axneg, sd_ayneg;

	status_t              res_status;

	// the pipeline never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (cfg_valid && cfg_ready)
			thr_q <= cfg_data;
	end

	segint_prep #(.CW(CW), .MW(MW)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.p1x      (seg1_start_x),
		.p1y      (seg1_start_y),
		.p2x      (seg1_end_x),
		.p2y      (seg1_end_y),
		.q1x      (seg2_start_x),
		.q1y      (seg2_start_y),
		.q2x      (seg2_end_x),
		.q2y      (seg2_end_y),
		.thr      (thr_q),
		.o_valid  (pre_valid),
		.o_dmag   (pre_dmag),
		.o_nmag   (pre_nmag),
		.o_pneg   (pre_pneg),
		.o_status (pre_status),
		.o_px     (pre_px),
		.o_py     (pre_py),
		.o_axm    (pre_axm),
		.o_aym    (pre_aym),
		.o_axneg  (pre_axneg),
		.o_ayneg  (pre_ayneg)
	);

	// carry everything the back end needs alongside the quotient
	assign side_in = {pre_status, pre_pneg, pre_px, pre_py, pre_axm, pre_aym,
		pre_axneg, pre_ayneg};

	segint_div #(.MW(MW), .PF(PF), .QW(QW), .SDW(SDW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pre_valid),
		.dmag     (pre_dmag),
		.nmag     (pre_nmag),
		.side_in  (side_in),
		.o_valid  (div_valid),
		.o_pmag   (div_pmag),
		.o_side   (side_out)
	);

	assign {sd_status, sd_pneg, sd_px, sd_py, sd_axm, sd_aym, sd_axneg, sd_ayneg} = side_out;

	// point sign: parameter sign against direction sign
	segint_place #(.CW(CW), .PF(PF), .QW(QW)) u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.pmag      (div_pmag),
		.status_in (status_t'(sd_status)),
		.px        (sd_px),
		.py        (sd_py),
		.axm       (sd_axm),
		.aym       (sd_aym),
		.xneg      (sd_pneg ^ sd_axneg),
		.yneg      (sd_pneg ^ sd_ayneg),
		.o_valid   (done),
		.o_status  (res_status),
		.o_x       (intersect_x),
		.o_y       (intersect_y)
	);

	assign status = res_status;

endmodule
`default_nettype wire

### rtl/segint_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module segint_chk import segint_pkg::*; #(
	parameter int COORD_WIDTH     = 24,
	parameter int PARAM_FRAC_BITS = 16
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   start,
	input wire                   busy,
	input wire                   cfg_valid,
	input wire                   cfg_ready,
	input wire                   done,
	input wire [1:0]             status,
	input wire [COORD_WIDTH-1:0] intersect_x,
	input wire [COORD_WIDTH-1:0] intersect_y
);
	localparam int LAT = PARAM_FRAC_BITS + COORD_WIDTH + 13;

	a_done_follows_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a word taken at the pipeline latency");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_PARALLEL || status == ST_INSIDE || status == ST_OUTSIDE))
		else $error("undefined status code");

	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_PARALLEL) |-> (intersect_x == '0 && intersect_y == '0))
		else $error("parallel result carries a nonzero point");

	a_never_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> (cfg_ready && !busy))
		else $error("pipeline refused a word");

endmodule

bind segment_intersection_test segint_chk #(
	.COORD_WIDTH     (COORD_WIDTH),
	.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_segint_chk (.*);
`default_nettype wire

### tb/segment_intersection_test_tb.sv
`timescale 1ns / 1ps
module segment_intersection_test_tb;
	import segint_pkg::*;

	localparam int CW = 24;
	localparam int PFB = 16;
	// wait long enough for the DUT pipeline to drain
	localparam int DRAIN = PFB + CW + 13 + 10;
	localparam logic signed [CW-1:0] CMIN = -24'sd8388608;
	localparam logic signed [CW-1:0] CMAX = 24'sd8388607;

	typedef struct packed {
		logic signed [CW-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
	} seg_pair_t;

	typedef struct packed {
		status_t              st;
		logic signed [CW-1:0] x, y;
	} crossing_t;

	typedef struct {
		seg_pair_t s;
		bit        typed;
		crossing_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	seg_pair_t segs = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THR_WIDTH-1:0] cfg_data = '0;
	logic done;
	logic [1:0] status;
	logic signed [CW-1:0] intersect_x, intersect_y;

	// typed expectation travels with the word that carries it
	logic typed_word = 1'b0;
	crossing_t typed_crossing = '0;

	logic [THR_WIDTH-1:0] thr_now = THR_RESET;
	crossing_t pending[$];
	int errors = 0;
	bit gaps_on = 1'b1;

	always #2 clk = ~clk;

	segment_intersection_test i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg1_start_x(segs.p1x), .seg1_start_y(segs.p1y),
		.seg1_end_x(segs.p2x), .seg1_end_y(segs.p2y),
		.seg2_start_x(segs.q1x), .seg2_start_y(segs.q1y),
		.seg2_end_x(segs.q2x), .seg2_end_y(segs.q2y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .intersect_x(intersect_x), .intersect_y(intersect_y)
	);

	// exact [0,1] test of n/d, both ends included
	function automatic bit in_unit(logic signed [127:0] n, logic signed [127:0] d);
		logic signed [127:0] an, ad;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		if (n == 0)
			return 1'b1;
		if ((n < 0) != (d < 0))
			return 1'b0;
		return ad >= an;
	endfunction

	// start + floor(param * dir / 2^PFB), clipped to the coordinate range
	function automatic logic signed [CW-1:0] place_point(logic signed [127:0] org,
			logic [127:0] pmag, bit pneg, logic signed [127:0] dir);
		logic [127:0] dmag;
		logic signed [127:0] prod, sum;
		dmag = dir < 0 ? -dir : dir;
		prod = pmag * dmag;
		if (pneg != (dir < 0))
			prod = -prod;
		prod = prod >>> PFB;
		sum = org + prod;
		if (sum > 128'sd8388607)
			return CMAX;
		if (sum < -128'sd8388608)
			return CMIN;
		return sum[CW-1:0];
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t s, logic [THR_WIDTH-1:0] thr);
		logic signed [127:0] px, py, ax, ay, cx, cy, bx, by, det, n1, n2;
		logic [127:0] dmag, nmag, q, pmag, lim;
		bit pneg;
		crossing_t r;
		px = s.p1x;
		py = s.p1y;
		ax = s.p2x - px;
		ay = s.p2y - py;
		cx = s.q2x - s.q1x;
		cy = s.q2y - s.q1y;
		bx = s.q1x - px;
		by = s.q1y - py;
		det = ax * cy - cx * ay;
		dmag = det < 0 ? -det : det;
		if (dmag <= thr)
			return '{ST_PARALLEL, '0, '0};
		n1 = cy * bx - cx * by;
		n2 = ay * bx - ax * by;
		nmag = n1 < 0 ? -n1 : n1;
		q = (nmag << PFB) / dmag;
		// past this magnitude any nonzero direction saturates anyway
		lim = 128'd1 << (PFB + CW + 1);
		pmag = q > lim ? lim : q;
		pneg = (n1 < 0) != (det < 0);
		r.st = (in_unit(n1, det) && in_unit(n2, det)) ? ST_INSIDE : ST_OUTSIDE;
		r.x = place_point(px, pmag, pneg, ax);
		r.y = place_point(py, pmag, pneg, ay);
		return r;
	endfunction

	// Check each strobed result against the oldest expectation, then record
	// the word taken at this edge. DUT outputs change by NBA, so values read
	// here are the ones from before the edge.
	always @(posedge clk) begin
		crossing_t e;
		if (done) begin
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: status %0d x %0d y %0d",
					$time, status, intersect_x, intersect_y);
				errors++;
			end else begin
				e = pending.pop_front();
				if (status !== e.st || intersect_x !== e.x || intersect_y !== e.y) begin
					$display("%0t: mismatch: expected status %0d x %0d y %0d, got %0d %0d %0d",
						$time, e.st, e.x, e.y, status, intersect_x, intersect_y);
					errors++;
				end
			end
		end
		if (start && !busy)
			pending.push_back(typed_word ? typed_crossing : predict_crossing(segs, thr_now));
	end

	// Drive one word, with an occasional idle burst ahead of it.
	task automatic send_word(seg_pair_t s, bit typed, crossing_t e);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		segs <= s;
		typed_word <= typed;
		typed_crossing <= e;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_empty();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_WIDTH-1:0] v);
		wait_empty();
		repeat (DRAIN) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		thr_now = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [CW-1:0] rnd_span(int span);
		return $signed(CW'($urandom_range(0, 2 * span))) - CW'(span);
	endfunction

	// Mix of shapes: small well-conditioned pairs, near-parallel pairs,
	// degenerate ones, wide ones that saturate, and raw noise.
	function automatic seg_pair_t random_pair();
		seg_pair_t s;
		int kind;
		int k;
		kind = $urandom_range(0, 9);
		s.p1x = rnd_span(4096); s.p1y = rnd_span(4096);
		s.p2x = rnd_span(4096); s.p2y = rnd_span(4096);
		s.q1x = rnd_span(4096); s.q1y = rnd_span(4096);
		s.q2x = rnd_span(4096); s.q2y = rnd_span(4096);
		case (kind)
			5: begin
				s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			end
			6: begin
				k = $urandom_range(1, 3);
				s.q2x = s.q1x + k * (s.p2x - s.p1x) + rnd_span(2);
				s.q2y = s.q1y + k * (s.p2y - s.p1y) + rnd_span(2);
			end
			7: begin
				if ($urandom_range(0, 1))
					s.p2x = s.p1x;
				else
					s.q1x = s.p2x;
				s.p2y = $urandom_range(0, 1) ? s.p1y : s.p2y;
				s.q1y = s.p2y;
			end
			8: begin
				s.p1x = rnd_span(4194304); s.p1y = rnd_span(4194304);
				s.p2x = rnd_span(4194304); s.p2y = rnd_span(4194304);
				s.q1x = rnd_span(4194304); s.q1y = rnd_span(4194304);
				s.q2x = rnd_span(4194304); s.q2y = rnd_span(4194304);
			end
			9: begin
				s.p2y = s.p1y;
				s.q2x = s.q1x;
			end
			default: ;
		endcase
		return s;
	endfunction

	row_t dir_rows[$];

	initial begin
		crossing_t none;
		logic [THR_WIDTH-1:0] thr_list[5];
		none = '0;
		thr_list = '{24'd0, 24'hFFFFFF, THR_RESET, 24'd1, 24'(($urandom_range(1, 20000)))};

		// p1x p1y p2x p2y q1x q1y q2x q2y; 1.0 is 256
		dir_rows = '{
			'{'0, 1, '{ST_PARALLEL, 0, 0}},
			'{'{0, 0, 512, 512, 0, 512, 512, 0}, 1, '{ST_INSIDE, 256, 256}},
			'{'{512, 512, 0, 0, 512, 0, 0, 512}, 1, '{ST_INSIDE, 256, 256}},
			'{'{0, 0, 512, 0, 512, 0, 512, 512}, 1, '{ST_INSIDE, 512, 0}},
			'{'{0, 0, 256, 0, 512, -256, 512, 256}, 1, '{ST_OUTSIDE, 512, 0}},
			'{'{0, 0, 512, 0, 256, 256, 256, 512}, 1, '{ST_OUTSIDE, 256, 0}},
			// determinant right at the reset threshold, then one above
			'{'{0, 0, 1, 0, 0, 0, 0, 1311}, 1, '{ST_PARALLEL, 0, 0}},
			'{'{0, 0, 1, 0, 0, 0, 0, 1312}, 0, none},
			'{'{0, 0, 512, 0, 256, 0, 768, 0}, 1, '{ST_PARALLEL, 0, 0}},
			'{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, '{ST_PARALLEL, 0, 0}},
			'{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1, '{ST_PARALLEL, 0, 0}},
			'{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 0, none},
			'{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 0, none},
			// nearly parallel long lines: intersection far off, saturates
			'{'{CMIN, 0, CMAX, 1, CMIN, 65536, CMAX, 65538}, 0, none},
			'{'{CMAX, 0, CMIN, 1, CMAX, -65536, CMIN, -65534}, 0, none},
			'{'{0, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 0, none}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].e);
		typed_word <= 1'b0;

		foreach (thr_list[p]) begin
			write_threshold(thr_list[p]);
			if (p == 4)
				gaps_on = 1'b0;
			for (int n = 0; n < 140; n++) begin
				// hold off once until the pipeline has fully drained
				if (p == 1 && n == 70)
					wait_empty();
				send_word(random_pair(), 1'b0, none);
			end
		end

		wait_empty();
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
